// ----- sv/lnls_pkg.sv -----
`default_nettype none
package lnls_pkg;

    localparam int NAMES  = 5;
    localparam int LEN    = 128;
    localparam int NAME_W = $clog2(NAMES);
    localparam int POS_W  = $clog2(LEN);
    localparam int NS_W   = $clog2(NAMES + 1);
    localparam int ADDR_W = NAME_W + POS_W;
    localparam int DEPTH  = NAMES << POS_W;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_SORT = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_NL    = 8'h0a;

    // controller to datapath
    typedef struct packed {
        logic load_byte;
        logic begin_sort;
        logic get_a;
        logic get_b;
        logic cmp_next;
        logic pair_done;
        logic rd_issue;
        logic rd_capture;
        logic out_load;
    } lnls_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic at_min;
        logic differ;
        logic sort_last;
        logic out_free;
    } lnls_status_t;

endpackage
`default_nettype wire

// ----- sv/lnls_ram.sv -----
`default_nettype none
module lnls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  wire  [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

// ----- sv/lnls_dp.sv -----
`default_nettype none
module lnls_dp
    import lnls_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire  [7:0]        in_byte,
    input  wire lnls_cmd_t    cmd,
    output lnls_status_t      status,
    input  wire               m_tready,
    output logic              m_tvalid,
    output logic [15:0]       m_tdata,
    output logic              m_tlast
);

    localparam logic [POS_W-1:0] LEN_MAX = POS_W'(LEN - 1);

    // line and sort state
    logic [POS_W-1:0]  lens_reg  [NAMES];
    logic [NAME_W-1:0] order_reg [NAMES];
    logic [NS_W-1:0]   ns_reg, ns_next;
    logic [POS_W-1:0]  lb_reg, lb_next;
    logic              ovf_reg, ovf_next;
    logic              in_tok_reg, in_tok_next;
    logic              drop_reg, drop_next;
    logic              phase_reg;
    logic [NS_W-1:0]   rank_reg;
    logic [POS_W-1:0]  pos_reg;

    // compare registers
    logic [NAME_W-1:0] k_reg, n_reg, ia_reg, ib_reg;
    logic [POS_W-1:0]  la_reg, lb_len_reg, i_reg;

    // pending result
    logic              p_mem_reg, p_end_reg, p_list_reg, p_empty_reg, p_exh_reg, p_ovf_reg;
    logic [2:0]        p_rank_reg;
    logic [7:0]        p_byte_reg;

    // output register
    logic              mv_reg;
    logic [15:0]       md_reg;
    logic              ml_reg;

    logic              wr_en;
    logic [NAME_W-1:0] wr_idx;
    logic [POS_W-1:0]  wr_pos;
    logic [7:0]        wr_data;
    logic [7:0]        ra, rb;
    logic [ADDR_W-1:0] addr_a, addr_b;

    // byte intake: clear on a fresh line, then strtok-style tokenizing
    always_comb begin
        logic              fresh;
        logic [NAME_W-1:0] idx;
        fresh       = phase_reg;
        ns_next     = fresh ? '0 : ns_reg;
        lb_next     = fresh ? '0 : lb_reg;
        ovf_next    = fresh ? 1'b0 : ovf_reg;
        in_tok_next = fresh ? 1'b0 : in_tok_reg;
        drop_next   = fresh ? 1'b0 : drop_reg;
        wr_en       = 1'b0;
        wr_data     = in_byte;
        idx         = '0;
        if (in_byte == CH_NL || in_byte == 8'd0) begin
        end else if (lb_next >= LEN_MAX) begin
            ovf_next = 1'b1;
        end else begin
            lb_next = lb_next + 1'b1;
            if (in_byte == CH_COMMA) begin
                in_tok_next = 1'b0;
                drop_next   = 1'b0;
            end else begin
                if (!in_tok_next && !drop_next) begin
                    if (ns_next >= NS_W'(NAMES)) begin
                        drop_next = 1'b1;
                        ovf_next  = 1'b1;
                    end else begin
                        in_tok_next = 1'b1;
                        ns_next     = ns_next + 1'b1;
                    end
                end
                if (!drop_next) begin
                    wr_en = 1'b1;
                    if (in_byte >= 8'h41 && in_byte <= 8'h5a) begin
                        wr_data = in_byte + 8'd32;
                    end
                end
            end
        end
        idx    = NAME_W'(ns_next - 1'b1);
        wr_idx = idx;
        wr_pos = fresh ? '0 : lens_reg[idx];
    end

    // readout selection
    logic [NAME_W-1:0] rd_k;
    logic [POS_W-1:0]  rd_len, rd_p;
    logic              rd_ok, rd_end;
    always_comb begin
        rd_ok  = phase_reg && (rank_reg < NS_W'(NAMES));
        rd_k   = order_reg[NAME_W'(rank_reg)];
        rd_len = lens_reg[rd_k];
        rd_p   = (pos_reg < rd_len) ? pos_reg : rd_len - 1'b1;
        rd_end = (rd_len == '0) || ((POS_W+1)'(rd_p) + 1'b1 >= (POS_W+1)'(rd_len));
    end

    assign addr_a = cmd.rd_issue ? {rd_k, rd_p} : {ia_reg, i_reg};
    assign addr_b = {ib_reg, i_reg};

    lnls_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .clk     (aclk),
        .we      (cmd.load_byte && wr_en),
        .waddr   ({wr_idx, wr_pos}),
        .wdata   (wr_data),
        .raddr_a (addr_a),
        .rdata_a (ra),
        .raddr_b (addr_b),
        .rdata_b (rb)
    );

    // compare status
    logic [POS_W-1:0]  nmin;
    logic              after;
    logic [NAME_W+1:0] ksum;
    assign nmin  = (la_reg < lb_len_reg) ? la_reg : lb_len_reg;
    assign after = (i_reg == nmin) ? (la_reg > lb_len_reg) : (ra > rb);
    assign ksum  = (NAME_W+2)'(k_reg) + (NAME_W+2)'(n_reg) + (NAME_W+2)'(2);

    assign status.at_min    = (i_reg == nmin);
    assign status.differ    = (ra != rb);
    assign status.sort_last = (ksum >= (NAME_W+2)'(NAMES)) &&
                              ((NAME_W+2)'(n_reg) + (NAME_W+2)'(2) >= (NAME_W+2)'(NAMES));
    assign status.out_free  = !mv_reg || m_tready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NAMES; j++) begin
                lens_reg[j]  <= '0;
                order_reg[j] <= NAME_W'(j);
            end
            ns_reg     <= '0;
            lb_reg     <= '0;
            ovf_reg    <= 1'b0;
            in_tok_reg <= 1'b0;
            drop_reg   <= 1'b0;
            phase_reg  <= 1'b0;
            rank_reg   <= '0;
            pos_reg    <= '0;
            k_reg      <= '0;
            n_reg      <= '0;
            mv_reg     <= 1'b0;
        end else begin
            if (cmd.load_byte) begin
                // stored byte grows its name; a fresh line clears the rest
                for (int j = 0; j < NAMES; j++) begin
                    if (wr_en && wr_idx == NAME_W'(j)) begin
                        lens_reg[j] <= wr_pos + 1'b1;
                    end else if (phase_reg) begin
                        lens_reg[j] <= '0;
                    end
                end
                if (phase_reg) begin
                    for (int j = 0; j < NAMES; j++) begin
                        order_reg[j] <= NAME_W'(j);
                    end
                    rank_reg <= '0;
                    pos_reg  <= '0;
                end
                ns_reg     <= ns_next;
                lb_reg     <= lb_next;
                ovf_reg    <= ovf_next;
                in_tok_reg <= in_tok_next;
                drop_reg   <= drop_next;
                phase_reg  <= 1'b0;
            end
            if (cmd.begin_sort) begin
                in_tok_reg <= 1'b0;
                drop_reg   <= 1'b0;
                phase_reg  <= 1'b1;
                rank_reg   <= '0;
                pos_reg    <= '0;
                k_reg      <= '0;
                n_reg      <= '0;
            end
            if (cmd.pair_done) begin
                if (after) begin
                    order_reg[k_reg]        <= ib_reg;
                    order_reg[k_reg + 1'b1] <= ia_reg;
                end
                if (ksum >= (NAME_W+2)'(NAMES)) begin
                    k_reg <= '0;
                    n_reg <= n_reg + 1'b1;
                end else begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            if (cmd.rd_issue && rd_ok) begin
                if (rd_end) begin
                    rank_reg <= rank_reg + 1'b1;
                    pos_reg  <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.get_a) begin
            ia_reg <= order_reg[k_reg];
            la_reg <= lens_reg[order_reg[k_reg]];
        end
        if (cmd.get_b) begin
            ib_reg     <= order_reg[k_reg + 1'b1];
            lb_len_reg <= lens_reg[order_reg[k_reg + 1'b1]];
            i_reg      <= '0;
        end
        if (cmd.cmp_next) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.rd_issue) begin
            p_mem_reg   <= rd_ok && (rd_len != '0);
            p_exh_reg   <= !rd_ok;
            p_ovf_reg   <= ovf_reg;
            p_rank_reg  <= rd_ok ? 3'(rank_reg) : 3'd0;
            p_end_reg   <= rd_ok && rd_end;
            p_list_reg  <= rd_ok && rd_end && (rank_reg == NS_W'(NAMES - 1));
            p_empty_reg <= rd_ok && (rd_len == '0);
        end
        if (cmd.rd_capture) begin
            p_byte_reg <= p_mem_reg ? ra : 8'd0;
        end
        if (cmd.out_load) begin
            md_reg <= {1'b0, p_ovf_reg, p_exh_reg, p_empty_reg, p_list_reg,
                       p_rank_reg, p_byte_reg};
            ml_reg <= p_end_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule
`default_nettype wire

// ----- sv/lnls_ctrl.sv -----
`default_nettype none
module lnls_ctrl
    import lnls_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    input  wire  [1:0]         in_cmd,
    output logic               s_tready,
    input  wire lnls_status_t  status,
    output lnls_cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GET_A = 3'd1;
    localparam logic [2:0] ST_GET_B = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_CHK   = 3'd4;
    localparam logic [2:0] ST_RD    = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       take;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tready && s_tvalid;

    // sequencing of intake, sort passes and readout
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (in_cmd)
                        CMD_BYTE: cmd.load_byte = 1'b1;
                        CMD_SORT: begin
                            cmd.begin_sort = 1'b1;
                            state_next     = ST_GET_A;
                        end
                        CMD_READ: begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_GET_A: begin
                cmd.get_a  = 1'b1;
                state_next = ST_GET_B;
            end
            ST_GET_B: begin
                cmd.get_b  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (status.at_min) begin
                    cmd.pair_done = 1'b1;
                    state_next    = status.sort_last ? ST_IDLE : ST_GET_A;
                end else begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (status.differ) begin
                    cmd.pair_done = 1'b1;
                    state_next    = status.sort_last ? ST_IDLE : ST_GET_A;
                end else begin
                    cmd.cmp_next = 1'b1;
                    state_next   = ST_CMP;
                end
            end
            ST_RD: begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/lowercase_name_list_sorter.sv -----
`default_nettype none
// Name list sorter. Send a line one byte per transfer with s_tuser = 0; it is
// split at commas into up to NAMES lower-cased names. s_tuser = 1 ends the line
// and bubble sorts the names; s_tuser = 2 requests the next sorted byte, which
// comes back as one m_ transfer (m_tlast marks the last byte of a name). A read
// steps through accept (RAM read issued), byte capture and output load, the
// last waiting until the output register is free; m_tvalid rises with the
// output load. The sort walks the stored names through one two-port RAM: each
// compared pair is fetched, then its byte pairs are examined in turn until they
// differ or the shorter name runs out, for NAMES*(NAMES-1)/2 pairs; input is
// stalled meanwhile.
module lowercase_name_list_sorter
    import lnls_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // line_byte[7:0]
    input  wire  [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], rank[10:8], list_end[11],
                                   // empty_name[12], exhausted[13], overflow[14]
    output logic        m_tlast    // name_end
);

    lnls_cmd_t    cmd;
    lnls_status_t status;

    lnls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_cmd   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lnls_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ----- bench/lnls_checker.sv -----
module lnls_checker
    import lnls_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [7:0]  s_tdata,
    input  wire [1:0]  s_tuser,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [15:0] m_tdata,
    input  wire        m_tlast,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic       overflow;
        logic       exhausted;
        logic       empty_name;
        logic       list_end;
        logic [2:0] rank;
        logic [7:0] out_byte;
        logic       name_end;
    } sorted_byte_t;

    // shadow copy of the sorter state
    logic [7:0] names_mem [NAMES][LEN];
    int         name_len [NAMES];
    int         order [NAMES];
    int         n_seen, n_bytes, rd_rank, rd_pos;
    logic       ovf, reading, in_tok, dropping;

    sorted_byte_t expected_bytes [$];

    assign pending = expected_bytes.size();

    function automatic void clear_line();
        for (int i = 0; i < NAMES; i++) begin
            name_len[i] = 0;
            order[i] = i;
        end
        n_seen = 0; n_bytes = 0; ovf = 0; rd_rank = 0; rd_pos = 0;
        in_tok = 0; dropping = 0;
    endfunction

    // true when name a orders strictly after name b
    function automatic bit sorts_after(int a, int b);
        int n;
        n = name_len[a] < name_len[b] ? name_len[a] : name_len[b];
        for (int i = 0; i < n; i++)
            if (names_mem[a][i] != names_mem[b][i])
                return names_mem[a][i] > names_mem[b][i];
        return name_len[a] > name_len[b];
    endfunction

    function automatic void store_byte(logic [7:0] c);
        if (c == CH_NL || c == 8'd0) return;
        if (n_bytes >= LEN - 1) begin
            ovf = 1;
            return;
        end
        n_bytes++;
        if (c == CH_COMMA) begin
            in_tok = 0;
            dropping = 0;
            return;
        end
        if (!in_tok && !dropping) begin
            if (n_seen >= NAMES) begin
                dropping = 1;
                ovf = 1;
            end else begin
                in_tok = 1;
                n_seen++;
            end
        end
        if (dropping) return;
        if (c >= "A" && c <= "Z") c = c + 8'd32;
        if (name_len[n_seen-1] < LEN) begin
            names_mem[n_seen-1][name_len[n_seen-1]] = c;
            name_len[n_seen-1]++;
        end
    endfunction

    function automatic void predict(logic [1:0] cmd, logic [7:0] c);
        sorted_byte_t r;
        int k, t, p;
        if (cmd == CMD_BYTE) begin
            if (reading) begin
                clear_line();
                reading = 0;
            end
            store_byte(c);
        end else if (cmd == CMD_SORT) begin
            in_tok = 0; dropping = 0;
            for (int n = 0; n < NAMES; n++)
                for (int j = 0; j + 1 + n < NAMES; j++)
                    if (sorts_after(order[j], order[j+1])) begin
                        t = order[j]; order[j] = order[j+1]; order[j+1] = t;
                    end
            reading = 1; rd_rank = 0; rd_pos = 0;
        end else if (cmd == CMD_READ) begin
            r = '0;
            r.overflow = ovf;
            if (!reading || rd_rank >= NAMES) begin
                r.exhausted = 1;
            end else begin
                k = order[rd_rank];
                r.rank = rd_rank[2:0];
                if (name_len[k] == 0) begin
                    r.empty_name = 1;
                    r.name_end = 1;
                end else begin
                    p = rd_pos < name_len[k] ? rd_pos : name_len[k] - 1;
                    r.out_byte = names_mem[k][p];
                    r.name_end = (p + 1 >= name_len[k]);
                end
                r.list_end = r.name_end && rd_rank == NAMES - 1;
                if (r.name_end) begin
                    rd_rank++;
                    rd_pos = 0;
                end else begin
                    rd_pos++;
                end
            end
            expected_bytes.push_back(r);
        end
    endfunction

    initial begin
        fail_count = 0;
        clear_line();
        reading = 0;
    end

    always @(posedge aclk) begin
        sorted_byte_t got, want;
        if (aresetn && s_tvalid && s_tready)
            predict(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[14:8], m_tdata[7:0], m_tlast};
            if (expected_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transfer: %h", got);
            end else begin
                want = expected_bytes.pop_front();
                if (got != want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: byte %h/%h rank %0d/%0d nend %b/%b lend %b/%b",
                            want.out_byte, got.out_byte, want.rank, got.rank,
                            want.name_end, got.name_end, want.list_end, got.list_end,
                            " empty %b/%b exh %b/%b ovf %b/%b (exp/act)",
                            want.empty_name, got.empty_name, want.exhausted,
                            got.exhausted, want.overflow, got.overflow);
                end
            end
        end
    end

endmodule

// ----- bench/tb_lowercase_name_list_sorter.sv -----
module tb_lowercase_name_list_sorter
    import lnls_pkg::*;
();

    // command value with no meaning, must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    lowercase_name_list_sorter i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

    lnls_checker i_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .fail_count, .pending
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one transfer on the input side, with random idle cycles before it;
    // tvalid stays up after the transfer until the next send or idle decides
    task automatic send(logic [1:0] cmd, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_char();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35) return 8'($urandom_range("a", "e"));
        if (sel < 60) return 8'($urandom_range("A", "E"));
        if (sel < 78) return CH_COMMA;
        if (sel < 82) return CH_NL;
        if (sel < 85) return 8'd0;
        return 8'($urandom_range(255));
    endfunction

    // one well-formed line: bytes, sort, then reads through the list
    task automatic send_line(int n_chars, int n_reads);
        for (int i = 0; i < n_chars; i++) send(CMD_BYTE, rand_char());
        send(CMD_SORT, 8'($urandom_range(255)));
        for (int i = 0; i < n_reads; i++) send(CMD_READ, 8'($urandom_range(255)));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send(CMD_BYTE, s[i]);
    endtask

    initial begin
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = CMD_BYTE;
        m_tready = 0; hold_cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: read before sort, mixed case, empties, unused command
        send(CMD_READ, 8'hff);
        send_text("Bob,,aLICE,");
        send(CMD_BYTE, CH_NL);
        send(CMD_BYTE, 8'd0);
        send(CMD_UNUSED, 8'h55);
        send_text("bo,Z");
        send(CMD_SORT, 8'h00);
        repeat (14) send(CMD_READ, 8'h00);
        send(CMD_SORT, 8'h00);
        send(CMD_READ, 8'h00);
        send_text("\xff\x80,Zz");
        send(CMD_SORT, 8'hff);
        repeat (4) send(CMD_READ, 8'h00);

        // long line and too many names
        for (int i = 0; i < 140; i++)
            send(CMD_BYTE, (i % 9 == 8) ? CH_COMMA : 8'(8'h41 + i % 26));
        send(CMD_SORT, 8'h00);
        repeat (40) send(CMD_READ, 8'h00);

        // back-pressure: receiver holds off while reads keep coming
        hold_cycles <= 300;
        send_line(10, 30);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 16 : 71) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 16 : 71) : 0;
            for (int j = 0; j < 380; ) begin
                int nc, nr;
                if ($urandom_range(9) == 0) begin
                    nc = 1;
                    send(2'($urandom_range(3)), 8'($urandom_range(255)));
                    j += 1;
                end else begin
                    nc = $urandom_range(1, 20);
                    nr = $urandom_range(0, 24);
                    send_line(nc, nr);
                    j += nc + nr + 1;
                end
            end
        end
        s_tvalid <= 0;

        wait (pending == 0);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("** lowercase_name_list_sorter: PASSED **");
        else
            $display("** lowercase_name_list_sorter: FAILED **");
        $finish;
    end

    initial begin
        #20000000;
        $display("** lowercase_name_list_sorter: FAILED **");
        $finish;
    end

endmodule
